// ===== design/ebpa_pkg.sv =====
// Shared types and codes for the extent bitmap page allocator.
`timescale 1ns / 1ps

package ebpa_pkg;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_DEALLOC = 2'd1;
   localparam logic [1:0] CMD_QUERY   = 2'd2;
   localparam logic [1:0] CMD_MAP     = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   localparam int          GROUP_BITS  = 8;
   localparam logic [12:0] LIMIT_RESET = 13'd4096;

   typedef struct packed {
      logic [1:0]  command;
      logic [11:0] page_id;
   } req_type;

   typedef struct packed {
      logic [11:0] result_page;
      logic [12:0] physical_page;
      logic        page_free;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    range_err;
   } cmd_entry_type;

endpackage

// ===== design/ebpa_front.sv =====
// Front end: accepts transactions, checks the page range and queues them for the back end.
`timescale 1ns / 1ps

module ebpa_front import ebpa_pkg::*; #(
   parameter int PAGES_PER_EXTENT = 256,
   parameter int NUM_EXTENTS      = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  req_type       req_data,
   output logic          q_empty,
   output cmd_entry_type q_head,
   input  logic          q_pop
);

   localparam int TOTAL_PAGES = PAGES_PER_EXTENT * NUM_EXTENTS;

   cmd_entry_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;
   cmd_entry_type new_entry;

   assign req_full = (count_ff == 2'd2);
   assign q_empty  = (count_ff == 2'd0);
   assign q_head   = entry_ff[rd_ptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && !q_empty;

   always_comb begin
      new_entry.req       = req_data;
      // Allocate ignores the page id, so it never fails the range check.
      new_entry.range_err = (req_data.command != CMD_ALLOC) &&
                            (32'(req_data.page_id) >= 32'(TOTAL_PAGES));
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ===== design/ebpa_back.sv =====
// Back end: sequencer that runs each command against the bitmap store and the counters.
`timescale 1ns / 1ps

module ebpa_back import ebpa_pkg::*; #(
   parameter int PAGES_PER_EXTENT = 256,
   parameter int NUM_EXTENTS      = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  cmd_entry_type q_head,
   output logic          q_pop,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [12:0]   csr_data,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_type       rsp_data
);

   localparam int EXT_W  = (NUM_EXTENTS > 1) ? $clog2(NUM_EXTENTS) : 1;
   localparam int OFF_W  = $clog2(PAGES_PER_EXTENT);
   localparam int CNT_W  = $clog2(PAGES_PER_EXTENT + 1);
   localparam int NGRP   = PAGES_PER_EXTENT / GROUP_BITS;
   localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int BIT_W  = $clog2(GROUP_BITS);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_SCAN = 4'b0100,
      S_PICK = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   logic [PAGES_PER_EXTENT-1:0]  mem [NUM_EXTENTS];
   logic [PAGES_PER_EXTENT-1:0]  rd_data_ff;
   logic                         rd_valid_ff;
   logic [NUM_EXTENTS-1:0]       row_valid_ff;
   logic [CNT_W-1:0]             used_ff [NUM_EXTENTS];
   logic [12:0]                  total_ff, total_in;
   logic [EXT_W:0]               extent_count_ff, extent_count_in;
   logic [12:0]                  limit_ff;
   cmd_entry_type                op_ff, op_in;
   logic [EXT_W-1:0]             ext_ff, ext_in;
   logic [OFF_W-1:0]             off_ff, off_in;
   logic [PAGES_PER_EXTENT-1:0]  row_ff, row_in;
   logic [NGRP-1:0]              grp_free_ff, grp_free_in;
   logic [GRP_W-1:0]             grp_ff, grp_in;
   logic                         out_valid_ff;
   rsp_type                      out_data_ff;

   logic                         rd_en, wr_en, finish, cnt_inc, cnt_dec;
   logic [EXT_W-1:0]             rd_addr, sel_ext;
   logic                         any_free;
   logic [PAGES_PER_EXTENT-1:0]  row_now, wr_data;
   logic [GRP_W-1:0]             sel_grp;
   logic [BIT_W-1:0]             sel_bit;
   logic [GROUP_BITS-1:0]        grp_bits;
   logic [OFF_W-1:0]             pick_off;
   logic                         cur_bit;
   rsp_type                      res;

   function automatic logic [12:0] phys_of(logic [EXT_W-1:0] e, logic [OFF_W-1:0] o);
      logic [31:0] p;
      p = 32'd2 + 32'(e) * 32'(PAGES_PER_EXTENT + 1) + 32'(o);
      return p[12:0];
   endfunction

   function automatic logic [11:0] page_of(logic [EXT_W-1:0] e, logic [OFF_W-1:0] o);
      logic [31:0] p;
      p = (32'(e) << OFF_W) | 32'(o);
      return p[11:0];
   endfunction

   assign csr_ready = 1'b1;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   // First extent that still has a free page.
   always_comb begin
      sel_ext  = '0;
      any_free = 1'b0;
      for (int i = NUM_EXTENTS - 1; i >= 0; i--) begin
         if (used_ff[i] < CNT_W'(PAGES_PER_EXTENT)) begin
            sel_ext  = EXT_W'(i);
            any_free = 1'b1;
         end
      end
   end

   // Group and bit searches for the lowest clear bit of the fetched row.
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_free_in[g] = ~&row_now[g*GROUP_BITS +: GROUP_BITS];
      end
      sel_grp = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_free_ff[g]) begin
            sel_grp = GRP_W'(g);
         end
      end
      grp_bits = row_ff[32'(grp_ff) * GROUP_BITS +: GROUP_BITS];
      sel_bit  = '0;
      for (int b = GROUP_BITS - 1; b >= 0; b--) begin
         if (!grp_bits[b]) begin
            sel_bit = BIT_W'(b);
         end
      end
      pick_off = OFF_W'(32'(grp_ff) * GROUP_BITS + 32'(sel_bit));
   end

   assign row_now = rd_valid_ff ? rd_data_ff : '0;
   assign cur_bit = row_now[off_ff];

   always_comb begin
      logic [31:0] pid_wide;
      pid_wide        = 32'(q_head.req.page_id);
      state_in        = state_ff;
      op_in           = op_ff;
      ext_in          = ext_ff;
      off_in          = off_ff;
      row_in          = row_ff;
      grp_in          = grp_ff;
      q_pop           = 1'b0;
      rd_en           = 1'b0;
      rd_addr         = ext_ff;
      wr_en           = 1'b0;
      wr_data         = row_ff;
      finish          = 1'b0;
      cnt_inc         = 1'b0;
      cnt_dec         = 1'b0;
      res             = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty && !out_valid_ff) begin
               q_pop = 1'b1;
               op_in = q_head;
               if (q_head.range_err) begin
                  finish     = 1'b1;
                  res.status = ST_RANGE;
               end else if (q_head.req.command == CMD_ALLOC) begin
                  if ((total_ff >= limit_ff) || !any_free) begin
                     finish     = 1'b1;
                     res.status = ST_FULL;
                  end else begin
                     ext_in   = sel_ext;
                     rd_addr  = sel_ext;
                     rd_en    = 1'b1;
                     state_in = S_READ;
                  end
               end else begin
                  ext_in   = EXT_W'(pid_wide >> OFF_W);
                  off_in   = pid_wide[OFF_W-1:0];
                  rd_addr  = EXT_W'(pid_wide >> OFF_W);
                  rd_en    = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            row_in   = row_now;
            state_in = S_IDLE;
            unique case (op_ff.req.command)
               CMD_ALLOC: begin
                  state_in = S_SCAN;
               end
               CMD_DEALLOC: begin
                  finish = 1'b1;
                  if (cur_bit) begin
                     wr_en            = 1'b1;
                     wr_data          = row_now;
                     wr_data[off_ff]  = 1'b0;
                     cnt_dec          = 1'b1;
                  end else begin
                     res.status = ST_NOT_ALLOC;
                  end
               end
               CMD_QUERY: begin
                  finish        = 1'b1;
                  res.page_free = !cur_bit;
               end
               default: begin
                  finish            = 1'b1;
                  res.physical_page = phys_of(ext_ff, off_ff);
               end
            endcase
         end
         S_SCAN: begin
            grp_in   = sel_grp;
            state_in = S_PICK;
         end
         default: begin
            finish            = 1'b1;
            wr_en             = 1'b1;
            wr_data           = row_ff;
            wr_data[pick_off] = 1'b1;
            cnt_inc           = 1'b1;
            res.result_page   = page_of(ext_ff, pick_off);
            res.physical_page = phys_of(ext_ff, pick_off);
            state_in          = S_IDLE;
         end
      endcase

      total_in        = total_ff;
      extent_count_in = extent_count_ff;
      if (cnt_inc) begin
         total_in = total_ff + 13'd1;
         if (extent_count_ff == (EXT_W + 1)'(ext_ff)) begin
            extent_count_in = extent_count_ff + (EXT_W + 1)'(1);
         end
      end else if (cnt_dec && (total_ff != 13'd0)) begin
         total_in = total_ff - 13'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         row_valid_ff    <= '0;
         total_ff        <= '0;
         extent_count_ff <= '0;
         limit_ff        <= LIMIT_RESET;
         out_valid_ff    <= 1'b0;
         for (int i = 0; i < NUM_EXTENTS; i++) begin
            used_ff[i] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         total_ff        <= total_in;
         extent_count_ff <= extent_count_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         if (wr_en) begin
            row_valid_ff[ext_ff] <= 1'b1;
         end
         if (cnt_inc) begin
            used_ff[ext_ff] <= used_ff[ext_ff] + CNT_W'(1);
         end else if (cnt_dec && (used_ff[ext_ff] != '0)) begin
            used_ff[ext_ff] <= used_ff[ext_ff] - CNT_W'(1);
         end
         if (finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ext_ff      <= ext_in;
      off_ff      <= off_in;
      row_ff      <= row_in;
      grp_free_ff <= grp_free_in;
      grp_ff      <= grp_in;
      if (finish) begin
         out_data_ff <= res;
      end
   end

   // Bitmap store, one row per extent.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ext_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

endmodule

// ===== design/extent_bitmap_page_allocator.sv =====
// Top level of the extent bitmap page allocator.
`timescale 1ns / 1ps

// Page allocator over NUM_EXTENTS extents of PAGES_PER_EXTENT pages (a power of
// two), each tracked by one bitmap row and a used-page count. Every request
// transaction (allocate, deallocate, query free, map) yields exactly one
// response transaction, in order. Requests enter a two-entry queue after a range
// check; a sequencer then runs them against a bitmap memory with a registered
// read port. Range errors and full allocates are answered from the idle state;
// deallocate, query and map read the row and answer from the read state, and
// allocate reads the row, scans the groups, then picks the bit with write-back
// in the same cycle. A new command starts only once the previous one is done
// and the response register is empty, so the sequencer holds one command at a
// time. Reset clears every row at once through per-row valid bits, so no
// clearing pass is needed. The page_limit register is written through the csr
// channel, which is always ready, and resets to 4096.

module extent_bitmap_page_allocator import ebpa_pkg::*; #(
   parameter int PAGES_PER_EXTENT = 256,
   parameter int NUM_EXTENTS      = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_data
);

   logic          q_empty;
   logic          q_pop;
   cmd_entry_type q_head;

   // The front end classifies and buffers requests so the requester is not
   // held while the sequencer works through a long allocate.
   ebpa_front #(
      .PAGES_PER_EXTENT(PAGES_PER_EXTENT),
      .NUM_EXTENTS     (NUM_EXTENTS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   // The back end owns all allocator state and the response register.
   ebpa_back #(
      .PAGES_PER_EXTENT(PAGES_PER_EXTENT),
      .NUM_EXTENTS     (NUM_EXTENTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

// ===== design/ebpa_checker.sv =====
// Port-level checks for the extent bitmap page allocator, bound to the top level.
`timescale 1ns / 1ps

module ebpa_checker import ebpa_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // Reset leaves no response pending and room for requests.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("pending transaction after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled response changed");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.status == ST_RANGE)) |->
      ((rsp_data.result_page == '0) && (rsp_data.physical_page == '0) &&
       !rsp_data.page_free))
      else $error("range error response carries data");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.status == ST_FULL)) |->
      ((rsp_data.result_page == '0) && (rsp_data.physical_page == '0) &&
       !rsp_data.page_free))
      else $error("full response carries data");

endmodule

bind extent_bitmap_page_allocator ebpa_checker u_ebpa_checker (
   .clock    (clock),
   .reset    (reset),
   .req_full (req_full),
   .rsp_empty(rsp_empty),
   .rsp_pop  (rsp_pop),
   .rsp_data (rsp_data)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the extent bitmap page allocator.
`timescale 1ns / 1ps

module tb_top;
   import ebpa_pkg::*;

   localparam int PAGES_PER_EXT = 256;
   localparam int EXT_NUM       = 16;
   localparam int PAGE_SPACE    = PAGES_PER_EXT * EXT_NUM;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   req_type     req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [12:0] csr_data;

   extent_bitmap_page_allocator #(
      .PAGES_PER_EXTENT(PAGES_PER_EXT),
      .NUM_EXTENTS(EXT_NUM)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   // Shadow copy of the allocator state, updated as each request transaction
   // is accepted.
   logic [PAGES_PER_EXT-1:0] shadow_bitmap [EXT_NUM];
   int unsigned              shadow_used [EXT_NUM];
   int unsigned              shadow_total;
   int unsigned              shadow_extents;
   logic [12:0]              shadow_limit;

   req_type     pending_reqs [$];
   rsp_type     expected_rsps [$];
   int unsigned error_count;
   bit          req_taken;
   bit          rsp_hold;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [12:0] phys_of(int unsigned page);
      int unsigned ext;
      ext = page / PAGES_PER_EXT;
      return 13'(2 + ext * (PAGES_PER_EXT + 1) + page % PAGES_PER_EXT);
   endfunction

   // Works out the response to one request and updates the shadow state.
   function automatic rsp_type allocator_step(req_type rq);
      rsp_type     rs;
      int unsigned ext;
      int unsigned off;
      int unsigned page;
      bit          found;
      rs = '0;
      rs.status = ST_OK;
      found = 1'b0;
      page = rq.page_id;
      if (rq.command == CMD_ALLOC) begin
         if (shadow_total < shadow_limit) begin
            for (int e = 0; e < EXT_NUM && !found; e++) begin
               if (shadow_used[e] < PAGES_PER_EXT) begin
                  for (int o = 0; o < PAGES_PER_EXT && !found; o++) begin
                     if (!shadow_bitmap[e][o]) begin
                        found = 1'b1;
                        ext = e;
                        off = o;
                     end
                  end
               end
            end
         end
         if (found) begin
            page = ext * PAGES_PER_EXT + off;
            shadow_bitmap[ext][off] = 1'b1;
            shadow_used[ext]++;
            shadow_total++;
            if (ext == shadow_extents) shadow_extents++;
            rs.result_page = 12'(page);
            rs.physical_page = phys_of(page);
         end else begin
            rs.status = ST_FULL;
         end
      end else if (page >= PAGE_SPACE) begin
         rs.status = ST_RANGE;
      end else begin
         ext = page / PAGES_PER_EXT;
         off = page % PAGES_PER_EXT;
         case (rq.command)
            CMD_DEALLOC: begin
               if (shadow_bitmap[ext][off]) begin
                  shadow_bitmap[ext][off] = 1'b0;
                  if (shadow_used[ext] > 0) shadow_used[ext]--;
                  if (shadow_total > 0) shadow_total--;
               end else begin
                  rs.status = ST_NOT_ALLOC;
               end
            end
            CMD_QUERY: begin
               rs.page_free = !shadow_bitmap[ext][off];
            end
            default: begin
               rs.physical_page = phys_of(page);
            end
         endcase
      end
      return rs;
   endfunction

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver: offers the oldest pending request, with random gaps between
   // transactions. Inputs change on the falling edge only. An offer is held
   // until the rising edge that accepts it; the gap drawn with an offer is
   // spent after that transaction completes.
   int unsigned drive_gap;
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         drive_gap = 0;
      end else if (req_push && !req_taken) begin
         req_push <= 1'b1;
      end else if (drive_gap > 0) begin
         req_push <= 1'b0;
         drive_gap--;
      end else if (pending_reqs.size() > 0) begin
         req_data <= pending_reqs[0];
         req_push <= 1'b1;
         drive_gap = pick_gap();
      end else begin
         req_push <= 1'b0;
      end
   end

   // Acceptance of request transactions at the rising edge feeds the predictor.
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_push && !req_full) begin
         expected_rsps.push_back(allocator_step(req_data));
         void'(pending_reqs.pop_front());
         req_taken = 1'b1;
      end
   end

   // Receiver pop control, with random stalls and an optional long hold-off.
   int unsigned pop_gap;
   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_pop <= 1'b0;
         pop_gap = 0;
      end else if (pop_gap > 0) begin
         pop_gap--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         pop_gap = pick_gap();
      end
   end

   // Monitor: compares each response transaction with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.result_page !== want.result_page) begin
               $error("result_page expected %0d actual %0d",
                      want.result_page, rsp_data.result_page);
               error_count++;
            end
            if (rsp_data.physical_page !== want.physical_page) begin
               $error("physical_page expected %0d actual %0d",
                      want.physical_page, rsp_data.physical_page);
               error_count++;
            end
            if (rsp_data.page_free !== want.page_free) begin
               $error("page_free expected %0d actual %0d",
                      want.page_free, rsp_data.page_free);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Writes page_limit; called only while the allocator is idle.
   task automatic write_limit(logic [12:0] value);
      @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_req(logic [1:0] cmd, logic [11:0] pid);
      req_type rq;
      rq.command = cmd;
      rq.page_id = pid;
      pending_reqs.push_back(rq);
   endfunction

   // Mostly ids in the low extents that are in play, sometimes anywhere.
   function automatic logic [11:0] rand_page();
      if ($urandom_range(0, 3) == 0) return 12'($urandom);
      return 12'($urandom_range(0, 2 * PAGES_PER_EXT + 40));
   endfunction

   task automatic random_phase(int unsigned count);
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) add_req(CMD_ALLOC, 12'($urandom));
         else if (pick < 6) add_req(CMD_DEALLOC, rand_page());
         else if (pick < 8) add_req(CMD_QUERY, rand_page());
         else add_req(CMD_MAP, rand_page());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      rsp_hold = 1'b0;
      req_taken = 1'b0;
      error_count = 0;
      for (int e = 0; e < EXT_NUM; e++) begin
         shadow_bitmap[e] = '0;
         shadow_used[e] = 0;
      end
      shadow_total = 0;
      shadow_extents = 0;
      shadow_limit = LIMIT_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: every command, freeing a free page, and queries and maps at
      // both ends of the page space.
      add_req(CMD_ALLOC, 12'hfff);
      add_req(CMD_ALLOC, 12'h000);
      add_req(CMD_QUERY, 12'd0);
      add_req(CMD_QUERY, 12'd2);
      add_req(CMD_DEALLOC, 12'd0);
      add_req(CMD_DEALLOC, 12'd0);
      add_req(CMD_MAP, 12'd0);
      add_req(CMD_MAP, 12'hfff);
      add_req(CMD_MAP, 12'd256);
      add_req(CMD_QUERY, 12'hfff);
      add_req(CMD_DEALLOC, 12'hfff);
      add_req(CMD_DEALLOC, 12'haaa);
      add_req(CMD_QUERY, 12'h555);
      add_req(CMD_ALLOC, 12'h555);
      add_req(CMD_ALLOC, 12'haaa);
      wait_drained();

      // A limit of zero makes every allocate report full.
      write_limit(13'd0);
      add_req(CMD_ALLOC, 12'd0);
      add_req(CMD_DEALLOC, 12'd1);
      add_req(CMD_ALLOC, 12'd0);
      wait_drained();

      // Small limit: allocates hit the limit, and frees reopen room.
      write_limit(13'd5);
      random_phase(250);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering, so the block
      // fills up and stalls its input.
      write_limit(13'h1fff);
      random_phase(40);
      rsp_hold = 1'b1;
      repeat (200) @(posedge clock);
      rsp_hold = 1'b0;
      random_phase(300);
      wait_drained();

      // Fill past the first extent so extent boundaries are crossed.
      write_limit(13'd300);
      repeat (280) add_req(CMD_ALLOC, 12'($urandom));
      random_phase(150);
      wait_drained();

      write_limit(LIMIT_RESET);
      random_phase(100);
      wait_drained();

      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(12 * 400000);
      $display("tb_top: errors");
      $finish;
   end

endmodule
